### hdl/rscore_pkg.sv
package rscore_pkg;

	// Defaults for the top-level parameters
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int TAG_WIDTH_DEF   = 16;

	// Fixed field widths
	localparam int TAG_FIELD_W = 16;
	localparam int SCORE_W     = 10;
	localparam int TOTAL_W     = 12;
	localparam int RANK_W      = 7;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_READ_DONE = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Request transaction
	typedef struct packed {
		op_t                    operation;
		logic [TAG_FIELD_W-1:0] record_tag;
		logic [SCORE_W-1:0]     score_first;
		logic [SCORE_W-1:0]     score_second;
		logic [SCORE_W-1:0]     score_third;
		logic [RANK_W-1:0]      rank_query;
	} req_t;

	// Response transaction
	typedef struct packed {
		status_t                status;
		logic [TAG_FIELD_W-1:0] out_tag;
		logic [SCORE_W-1:0]     out_first;
		logic [SCORE_W-1:0]     out_second;
		logic [SCORE_W-1:0]     out_third;
		logic [TOTAL_W-1:0]     out_total;
		logic [SCORE_W-1:0]     out_average;
		logic [RANK_W-1:0]      out_rank;
	} rsp_t;

	// total / 3 via reciprocal: (t * 2731) >> 13 is exact for t < 8192
	function automatic logic [SCORE_W-1:0] div3(input logic [TOTAL_W-1:0] t);
		logic [TOTAL_W+12-1:0] p;
		p = {12'd0, t} * {{TOTAL_W{1'b0}}, 12'd2731};
		return p[13 +: SCORE_W];
	endfunction

endpackage

### hdl/ranked_score_table.sv
// Ranked score table: records kept in descending order of total score.
// Request channel (req_valid/req_ready/req): an insert carries a tag and three
// scores; a read carries a one-based rank. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one transaction per request, in order.
// An insert walks up from the bottom of the table, moving each entry whose
// total is not greater than the new one down a place, one entry at a time
// (memory read, then compare and write back on the table).
// A full-table insert or a read of an empty rank is answered without a table
// access. The next request is taken only once the response has moved into
// the output register.
// One request is worked on at a time; req_ready is high while the block is
// idle, also while a finished response still waits in the output register.
// If the receiver stalls, the next result is held in a staging register
// until the output register frees up.
// Reset clears the entry count and all control state; the table memory is
// not cleared, as only entries below the count are ever read.
module ranked_score_table #(
	parameter int TABLE_DEPTH = rscore_pkg::TABLE_DEPTH_DEF,
	parameter int TAG_WIDTH   = rscore_pkg::TAG_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rscore_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rscore_pkg::rsp_t  rsp
);

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > rscore_pkg::RANK_W) ? CW : rscore_pkg::RANK_W;

	typedef struct packed {
		logic [TAG_WIDTH-1:0]           tag;
		logic [rscore_pkg::SCORE_W-1:0] s1;
		logic [rscore_pkg::SCORE_W-1:0] s2;
		logic [rscore_pkg::SCORE_W-1:0] s3;
		logic [rscore_pkg::TOTAL_W-1:0] total;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_READ,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	entry_t            ins_q;
	rscore_pkg::rsp_t  res_q;
	rscore_pkg::rsp_t  res_out;
	rscore_pkg::rsp_t  rsp_q;
	logic              rsp_valid_q;

	// Table memory, one write and one registered read per cycle
	entry_t            mem [TABLE_DEPTH];
	entry_t            mem_rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	entry_t            mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	logic              accept;
	entry_t            new_entry;
	logic [CMPW-1:0]   q_ext;
	logic [CMPW-1:0]   cnt_ext;
	logic              rank_bad;
	logic              table_full;
	logic              ins_here;
	logic [AW:0]       ins_rank;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Incoming record, tag cut to the stored width
	always_comb begin
		new_entry.tag   = TAG_WIDTH'(req.record_tag);
		new_entry.s1    = req.score_first;
		new_entry.s2    = req.score_second;
		new_entry.s3    = req.score_third;
		new_entry.total = rscore_pkg::TOTAL_W'(req.score_first)
			+ rscore_pkg::TOTAL_W'(req.score_second)
			+ rscore_pkg::TOTAL_W'(req.score_third);
	end

	// Staged result with its average filled in
	always_comb begin
		res_out             = res_q;
		res_out.out_average = rscore_pkg::div3(res_q.out_total);
	end

	assign q_ext      = CMPW'(req.rank_query);
	assign cnt_ext    = CMPW'(count_q);
	assign rank_bad   = (q_ext == '0) || (q_ext > cnt_ext);
	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign ins_here   = (mem_rd_q.total > ins_q.total);
	assign ins_rank   = {1'b0, idx_q} + {{AW{1'b0}}, 1'b1};

	// Memory control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = ins_q;
		mem_re = 1'b0;
		mem_ra = idx_q - AW'(1);
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.operation == rscore_pkg::OP_READ && !rank_bad) begin
					mem_re = 1'b1;
					mem_ra = AW'(req.rank_query - rscore_pkg::RANK_W'(1));
				end
			end
			S_SCAN_RD: begin
				if (idx_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_SCAN_CMP: begin
				mem_we = 1'b1;
				if (!ins_here) begin
					mem_wd = mem_rd_q;
				end
			end
			S_READ, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			ins_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.operation == rscore_pkg::OP_INSERT) begin
							ins_q <= new_entry;
							if (table_full) begin
								res_q.status     <= rscore_pkg::ST_FULL;
								res_q.out_tag    <= rscore_pkg::TAG_FIELD_W'(new_entry.tag);
								res_q.out_first  <= new_entry.s1;
								res_q.out_second <= new_entry.s2;
								res_q.out_third  <= new_entry.s3;
								res_q.out_total  <= new_entry.total;
								res_q.out_rank   <= '0;
								state_q          <= S_EMIT;
							end else begin
								idx_q   <= AW'(count_q);
								state_q <= S_SCAN_RD;
							end
						end else if (rank_bad) begin
							res_q.status     <= rscore_pkg::ST_EMPTY;
							res_q.out_tag    <= '0;
							res_q.out_first  <= '0;
							res_q.out_second <= '0;
							res_q.out_third  <= '0;
							res_q.out_total  <= '0;
							res_q.out_rank   <= '0;
							state_q          <= S_EMIT;
						end else begin
							res_q.out_rank <= req.rank_query;
							state_q        <= S_READ;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == '0) begin
						count_q          <= count_q + CW'(1);
						res_q.status     <= rscore_pkg::ST_INSERTED;
						res_q.out_tag    <= rscore_pkg::TAG_FIELD_W'(ins_q.tag);
						res_q.out_first  <= ins_q.s1;
						res_q.out_second <= ins_q.s2;
						res_q.out_third  <= ins_q.s3;
						res_q.out_total  <= ins_q.total;
						res_q.out_rank   <= rscore_pkg::RANK_W'(1);
						state_q          <= S_EMIT;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (ins_here) begin
						count_q          <= count_q + CW'(1);
						res_q.status     <= rscore_pkg::ST_INSERTED;
						res_q.out_tag    <= rscore_pkg::TAG_FIELD_W'(ins_q.tag);
						res_q.out_first  <= ins_q.s1;
						res_q.out_second <= ins_q.s2;
						res_q.out_third  <= ins_q.s3;
						res_q.out_total  <= ins_q.total;
						res_q.out_rank   <= rscore_pkg::RANK_W'(ins_rank);
						state_q          <= S_EMIT;
					end else begin
						// entry moved down a place, carry on upwards
						idx_q   <= idx_q - AW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_READ: begin
					res_q.status     <= rscore_pkg::ST_READ_DONE;
					res_q.out_tag    <= rscore_pkg::TAG_FIELD_W'(mem_rd_q.tag);
					res_q.out_first  <= mem_rd_q.s1;
					res_q.out_second <= mem_rd_q.s2;
					res_q.out_third  <= mem_rd_q.s3;
					res_q.out_total  <= mem_rd_q.total;
					state_q          <= S_EMIT;
				end
				S_EMIT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_out;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
